@@ src/prtv_pkg.sv @@
// Shared widths and the front-end result type for the pair velocity decomposition.
// No dependencies.
package prtv_pkg;

  localparam int unsigned IN_W   = 32;  // input field width
  localparam int unsigned MAG_W  = 33;  // magnitude of a coordinate difference
  localparam int unsigned SQ_W   = 66;  // sum of three products of magnitudes
  localparam int unsigned QUO_W  = 36;  // quotient bits of the radial division
  localparam int unsigned RAD_W  = 34;  // signed radial velocity
  localparam int unsigned AXES   = 3;

  // Front-end output: squared norms and the signed dot product
  typedef struct packed {
    logic              valid;
    logic [SQ_W-1:0]   psq;
    logic [SQ_W-1:0]   vsq;
    logic [SQ_W-1:0]   dot_mag;
    logic              dot_neg;
    logic              zero;
  } prtv_front_t;

endpackage

@@ src/pair_radial_tangential_velocity.sv @@
// Top level of the pair radial / tangential velocity decomposition.
// Depends on prtv_pkg, prtv_front, prtv_sqrt and prtv_div.
//
// One transaction per clock: busy_o stays low and a new pair may start in every
// cycle. Each result reaches done_o through the four-stage front end, the
// 33-stage separation root, the 36-stage radial divider, one multiply and one
// subtract stage, the 33-stage tangential root and the output register. Results
// come out in start order and cannot be stalled; zero_separation_o marks a
// coincident pair, for which both velocity components read zero.
module pair_radial_tangential_velocity import prtv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [IN_W-1:0]   first_pos_x_i,
  input  logic [IN_W-1:0]   first_pos_y_i,
  input  logic [IN_W-1:0]   first_pos_z_i,
  input  logic [IN_W-1:0]   second_pos_x_i,
  input  logic [IN_W-1:0]   second_pos_y_i,
  input  logic [IN_W-1:0]   second_pos_z_i,
  input  logic [IN_W-1:0]   first_vel_x_i,
  input  logic [IN_W-1:0]   first_vel_y_i,
  input  logic [IN_W-1:0]   first_vel_z_i,
  input  logic [IN_W-1:0]   second_vel_x_i,
  input  logic [IN_W-1:0]   second_vel_y_i,
  input  logic [IN_W-1:0]   second_vel_z_i,
  output logic              done_o,
  output logic [MAG_W-1:0]  separation_o,
  output logic [RAD_W-1:0]  radial_velocity_o,
  output logic [MAG_W-1:0]  tangential_velocity_o,
  output logic              zero_separation_o
);

  localparam int unsigned S1_SIDE = 2*SQ_W + 2;
  localparam int unsigned DV_SIDE = SQ_W + MAG_W + 2;
  localparam int unsigned S2_SIDE = MAG_W + RAD_W + 1;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  prtv_front_t front;

  // never stalls
  assign busy_o = 1'b0;

  prtv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .pos_a_i ({first_pos_z_i, first_pos_y_i, first_pos_x_i}),
    .pos_b_i ({second_pos_z_i, second_pos_y_i, second_pos_x_i}),
    .vel_a_i ({first_vel_z_i, first_vel_y_i, first_vel_x_i}),
    .vel_b_i ({second_vel_z_i, second_vel_y_i, second_vel_x_i}),
    .front_o (front)
  );

  // separation root
  logic               s1_vld;
  logic [MAG_W-1:0]   s1_sep;
  logic [S1_SIDE-1:0] s1_side;
  logic [SQ_W-1:0]    s1_vsq, s1_dot;
  logic               s1_neg, s1_zero;

  prtv_sqrt #(.ROOT_W(MAG_W), .SIDE_W(S1_SIDE)) u_sqrt_sep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front.valid),
    .rad_i   (front.psq),
    .side_i  ({front.vsq, front.dot_mag, front.dot_neg, front.zero}),
    .valid_o (s1_vld),
    .root_o  (s1_sep),
    .side_o  (s1_side)
  );

  assign {s1_vsq, s1_dot, s1_neg, s1_zero} = s1_side;

  // radial magnitude = dot / separation
  logic               dv_vld;
  logic [QUO_W-1:0]   dv_quo;
  logic [DV_SIDE-1:0] dv_side;
  logic [SQ_W-1:0]    dv_vsq;
  logic [MAG_W-1:0]   dv_sep;
  logic               dv_neg, dv_zero;

  prtv_div #(.QUO_W(QUO_W), .DEN_W(MAG_W), .SIDE_W(DV_SIDE)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_vld),
    .num_hi_i (MAG_W'(s1_dot[SQ_W-1:QUO_W])),
    .num_lo_i (s1_dot[QUO_W-1:0]),
    .den_i    (s1_sep),
    .side_i   ({s1_vsq, s1_sep, s1_neg, s1_zero}),
    .valid_o  (dv_vld),
    .quo_o    (dv_quo),
    .side_o   (dv_side)
  );

  assign {dv_vsq, dv_sep, dv_neg, dv_zero} = dv_side;

  // multiply stage: saturate and square the radial magnitude
  logic             m_vld_q, t_vld_q;
  logic [MAG_W-1:0] m_rad_q, m_sep_q, t_sep_q;
  logic [SQ_W-1:0]  m_par2_q, m_vsq_q, t_s_q;
  logic             m_neg_q, m_zero_q, t_zero_q;
  logic [RAD_W-1:0] t_rad_q;
  logic [MAG_W-1:0] rad_sat;

  assign rad_sat = (dv_quo[QUO_W-1:MAG_W] != '0) ? MAG_MAX : dv_quo[MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      t_vld_q <= 1'b0;
    end else begin
      m_vld_q <= dv_vld;
      t_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_rad_q  <= rad_sat;
    m_par2_q <= rad_sat * rad_sat;
    m_vsq_q  <= dv_vsq;
    m_sep_q  <= dv_sep;
    m_neg_q  <= dv_neg;
    m_zero_q <= dv_zero;
  end

  // subtract stage: clamp the root argument, sign the radial velocity
  always_ff @(posedge clk_i) begin
    t_s_q    <= (m_vsq_q >= m_par2_q) ? m_vsq_q - m_par2_q : '0;
    t_rad_q  <= m_zero_q ? '0 :
                m_neg_q  ? RAD_W'(-{1'b0, m_rad_q}) : {1'b0, m_rad_q};
    t_sep_q  <= m_sep_q;
    t_zero_q <= m_zero_q;
  end

  // tangential root
  logic               s2_vld;
  logic [MAG_W-1:0]   s2_tan, s2_sep;
  logic [S2_SIDE-1:0] s2_side;
  logic [RAD_W-1:0]   s2_rad;
  logic               s2_zero;

  prtv_sqrt #(.ROOT_W(MAG_W), .SIDE_W(S2_SIDE)) u_sqrt_tan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t_vld_q),
    .rad_i   (t_s_q),
    .side_i  ({t_sep_q, t_rad_q, t_zero_q}),
    .valid_o (s2_vld),
    .root_o  (s2_tan),
    .side_o  (s2_side)
  );

  assign {s2_sep, s2_rad, s2_zero} = s2_side;

  // output register
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    separation_o          <= s2_sep;
    radial_velocity_o     <= s2_rad;
    tangential_velocity_o <= s2_zero ? '0 : s2_tan;
    zero_separation_o     <= s2_zero;
  end

  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_zero_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_separation_o |-> radial_velocity_o == '0 && tangential_velocity_o == '0)
    else $error("zero separation with nonzero velocity component");

  a_zero_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> zero_separation_o == (separation_o == '0))
    else $error("zero flag disagrees with separation");

  a_rad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> radial_velocity_o != {1'b1, {(RAD_W-1){1'b0}}})
    else $error("radial velocity outside saturated range");
`endif

endmodule

@@ src/prtv_front.sv @@
// Four-stage front end: differences, products, sums and dot-product sign.
// Depends on prtv_pkg.
module prtv_front import prtv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [AXES-1:0][IN_W-1:0] pos_a_i,
  input  logic [AXES-1:0][IN_W-1:0] pos_b_i,
  input  logic [AXES-1:0][IN_W-1:0] vel_a_i,
  input  logic [AXES-1:0][IN_W-1:0] vel_b_i,
  output prtv_front_t             front_o
);

  logic [3:0] vld_q;

  logic [AXES-1:0][MAG_W-1:0] mp_q, mv_q;
  logic [AXES-1:0]            sp_q, sv_q;
  logic [AXES-1:0][SQ_W-1:0]  pp_q, vv_q, pv_q;
  logic [AXES-1:0]            sg_q;
  logic [SQ_W-1:0]            psq_q, vsq_q, dpos_q, dneg_q;
  logic [SQ_W-1:0]            psq4_q, vsq4_q, dot_q;
  logic                       neg_q, zero_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // stage 1: differences as sign and magnitude
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < AXES; i++) begin
      logic signed [MAG_W-1:0] dp, dv;
      dp = $signed({pos_a_i[i][IN_W-1], pos_a_i[i]}) - $signed({pos_b_i[i][IN_W-1], pos_b_i[i]});
      dv = $signed({vel_a_i[i][IN_W-1], vel_a_i[i]}) - $signed({vel_b_i[i][IN_W-1], vel_b_i[i]});
      sp_q[i] <= dp[MAG_W-1];
      sv_q[i] <= dv[MAG_W-1];
      mp_q[i] <= dp[MAG_W-1] ? MAG_W'(-dp) : MAG_W'(dp);
      mv_q[i] <= dv[MAG_W-1] ? MAG_W'(-dv) : MAG_W'(dv);
    end
  end

  // stage 2: products of magnitudes
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < AXES; i++) begin
      pp_q[i] <= mp_q[i] * mp_q[i];
      vv_q[i] <= mv_q[i] * mv_q[i];
      pv_q[i] <= mp_q[i] * mv_q[i];
      sg_q[i] <= sp_q[i] ^ sv_q[i];
    end
  end

  // stage 3: sums, dot product split by sign
  always_ff @(posedge clk_i) begin
    logic [SQ_W-1:0] pos_sum, neg_sum;
    pos_sum = '0;
    neg_sum = '0;
    for (int i = 0; i < AXES; i++) begin
      if (sg_q[i]) neg_sum = neg_sum + pv_q[i];
      else         pos_sum = pos_sum + pv_q[i];
    end
    psq_q  <= pp_q[0] + pp_q[1] + pp_q[2];
    vsq_q  <= vv_q[0] + vv_q[1] + vv_q[2];
    dpos_q <= pos_sum;
    dneg_q <= neg_sum;
  end

  // stage 4: dot product magnitude and sign, zero-separation test
  always_ff @(posedge clk_i) begin
    neg_q  <= dneg_q > dpos_q;
    dot_q  <= (dneg_q > dpos_q) ? dneg_q - dpos_q : dpos_q - dneg_q;
    psq4_q <= psq_q;
    vsq4_q <= vsq_q;
    zero_q <= psq_q == '0;
  end

  assign front_o = '{valid: vld_q[3], psq: psq4_q, vsq: vsq4_q, dot_mag: dot_q,
                     dot_neg: neg_q, zero: zero_q};

endmodule

@@ src/prtv_sqrt.sv @@
// Pipelined floor square root, one root bit per register stage, with sideband.
// No dependencies.
module prtv_sqrt #(
  parameter int unsigned ROOT_W = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned RW = ROOT_W + 2;

  logic [ROOT_W-1:0]   vld_q;
  logic [RW-1:0]       rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W];
  logic [SIDE_W-1:0]   side_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic                cur_vld;
    logic [RW-1:0]       cur_rem;
    logic [ROOT_W-1:0]   cur_root;
    logic [2*ROOT_W-1:0] cur_rad;
    logic [SIDE_W-1:0]   cur_side;
    logic [RW+1:0]       trial, cand;

    if (s == 0) begin : g_first
      assign cur_vld  = valid_i;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = rad_i;
      assign cur_side = side_i;
    end else begin : g_next
      assign cur_vld  = vld_q[s-1];
      assign cur_rem  = rem_q[s-1];
      assign cur_root = root_q[s-1];
      assign cur_rad  = rad_q[s-1];
      assign cur_side = side_q[s-1];
    end

    // bring down two radicand bits, try root*4+1
    assign trial = {cur_rem, cur_rad[2*ROOT_W-1 -: 2]};
    assign cand  = {2'b00, cur_root, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (trial >= cand) begin
        rem_q[s]  <= RW'(trial - cand);
        root_q[s] <= {cur_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[s]  <= RW'(trial);
        root_q[s] <= {cur_root[ROOT_W-2:0], 1'b0};
      end
      rad_q[s]  <= {cur_rad[2*ROOT_W-3:0], 2'b00};
      side_q[s] <= cur_side;
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

@@ src/prtv_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage, with sideband.
// No dependencies; the caller guarantees the quotient fits in QUO_W bits.
module prtv_div #(
  parameter int unsigned QUO_W  = 36,
  parameter int unsigned DEN_W  = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [DEN_W-1:0]   num_hi_i,   // upper numerator bits, below den
  input  logic [QUO_W-1:0]   num_lo_i,
  input  logic [DEN_W-1:0]   den_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic [QUO_W-1:0]   quo_o,
  output logic [SIDE_W-1:0]  side_o
);

  logic [QUO_W-1:0]  vld_q;
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  lo_q   [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic              cur_vld;
    logic [DEN_W-1:0]  cur_rem, cur_den;
    logic [QUO_W-1:0]  cur_lo, cur_quo;
    logic [SIDE_W-1:0] cur_side;
    logic [DEN_W:0]    trial;

    if (s == 0) begin : g_first
      assign cur_vld  = valid_i;
      assign cur_rem  = num_hi_i;
      assign cur_lo   = num_lo_i;
      assign cur_quo  = '0;
      assign cur_den  = den_i;
      assign cur_side = side_i;
    end else begin : g_next
      assign cur_vld  = vld_q[s-1];
      assign cur_rem  = rem_q[s-1];
      assign cur_lo   = lo_q[s-1];
      assign cur_quo  = quo_q[s-1];
      assign cur_den  = den_q[s-1];
      assign cur_side = side_q[s-1];
    end

    // shift in the next numerator bit and try a subtract
    assign trial = {cur_rem, cur_lo[QUO_W-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (trial >= {1'b0, cur_den}) begin
        rem_q[s] <= DEN_W'(trial - {1'b0, cur_den});
        quo_q[s] <= {cur_quo[QUO_W-2:0], 1'b1};
      end else begin
        rem_q[s] <= DEN_W'(trial);
        quo_q[s] <= {cur_quo[QUO_W-2:0], 1'b0};
      end
      lo_q[s]   <= {cur_lo[QUO_W-2:0], 1'b0};
      den_q[s]  <= cur_den;
      side_q[s] <= cur_side;
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule
